// File: rtl/julia_escape_time_pixel_macros.svh
// assertion macros shared by the julia escape-time pixel rtl
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH

// checked only while out of reset
`define JETP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define JETP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/jetp_pkg.sv
// shared types, constants and helpers of the julia escape-time pixel block
`timescale 1ns / 1ps
`default_nettype none

package jetp_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 26;
  localparam int unsigned IndexW   = 12;
  localparam int unsigned CountW   = 10;
  localparam int unsigned WideW    = 48;   // headroom for every exact sum before saturation

  localparam int unsigned MaxIterations = 1000;
  localparam int unsigned MaxResolution = 4096;

  // index reduction by reciprocal multiply, one correction step
  localparam int unsigned RecipShift = 24;
  localparam int unsigned ResRecip   = (1 << RecipShift) / MaxResolution;
  localparam int unsigned ResW       = 17;  // holds the resolution itself

  localparam logic signed [DataW+1:0] EscapeLimit = (DataW+2)'(4 * (1 << FracBits));

  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegCReal  = 3'd0,
    RegCImag  = 3'd1,
    RegXStart = 3'd2,
    RegYStart = 3'd3,
    RegStepX  = 3'd4,
    RegStepY  = 3'd5
  } jetp_reg_e;

  localparam logic signed [DataW-1:0] CRealRst  = 32'sd19126353;
  localparam logic signed [DataW-1:0] CImagRst  = 32'sd671089;
  localparam logic signed [DataW-1:0] XStartRst = -32'sd134217728;
  localparam logic signed [DataW-1:0] YStartRst = -32'sd134217728;
  localparam logic signed [DataW-1:0] StepXRst  = 32'sd419430;
  localparam logic signed [DataW-1:0] StepYRst  = 32'sd559241;

  typedef struct packed {
    logic signed [DataW-1:0] c_real;
    logic signed [DataW-1:0] c_imag;
    logic signed [DataW-1:0] x_start;
    logic signed [DataW-1:0] y_start;
    logic signed [DataW-1:0] step_x;
    logic signed [DataW-1:0] step_y;
  } cfg_t;

  // start point handed from front to back
  typedef struct packed {
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } point_t;

  // clamp a wide signed value to the 32-bit range
  function automatic logic signed [DataW-1:0] sat(input logic signed [WideW-1:0] v);
    logic [WideW-DataW:0] top;
    logic signed [DataW-1:0] res;
    top = v[WideW-1:DataW-1];
    if (top == '0 || top == '1) begin
      res = v[DataW-1:0];
    end else if (v[WideW-1]) begin
      res = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DataW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/julia_escape_time_pixel.sv
// julia set escape-time evaluator for one pixel per beat, top level
// path: 4 front stages, start-point queue, load, a multiply and an accumulate step per escape test, done, result queue
// the loop takes a new pixel only once the last count is pushed; escape tests run are count+1, or the limit
// the worst case, MAX_ITERATIONS tests, is set by the shared square-add loop (3 multipliers, 2 steps)
// reset: config registers return to their defaults, queues and pipe empty, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_pixel #(
  parameter int unsigned MAX_ITERATIONS = jetp_pkg::MaxIterations
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input queue side
  input  logic                                push,
  output logic                                full,
  input  logic [jetp_pkg::IndexW-1:0]         column_i,
  input  logic [jetp_pkg::IndexW-1:0]         row_i,
  // result queue side
  output logic                                empty,
  input  logic                                pop,
  output logic [jetp_pkg::CountW-1:0]         iteration_count_o,
  // register write port
  input  logic                                cfg_we_i,
  input  logic [jetp_pkg::RegIdxW-1:0]        cfg_idx_i,
  input  logic [jetp_pkg::DataW-1:0]          cfg_wdata_i
);

  localparam int unsigned PointW = $bits(jetp_pkg::point_t);

  jetp_pkg::cfg_t   cfg_q, cfg_d;

  // front to queue
  logic             fr_stall, fr_valid, mid_full;
  jetp_pkg::point_t fr_point;
  // queue to back
  logic             mid_empty, core_pop;
  logic [PointW-1:0] mid_data;
  jetp_pkg::point_t core_point;
  // back to result queue
  logic             core_push, res_full;
  logic [jetp_pkg::CountW-1:0] core_count;

  // config registers; the user must write them only between pixels, the block itself does not enforce it
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jetp_pkg::RegCReal:  cfg_d.c_real  = cfg_wdata_i;
        jetp_pkg::RegCImag:  cfg_d.c_imag  = cfg_wdata_i;
        jetp_pkg::RegXStart: cfg_d.x_start = cfg_wdata_i;
        jetp_pkg::RegYStart: cfg_d.y_start = cfg_wdata_i;
        jetp_pkg::RegStepX:  cfg_d.step_x  = cfg_wdata_i;
        jetp_pkg::RegStepY:  cfg_d.step_y  = cfg_wdata_i;
        default: begin
          cfg_d = cfg_q;  // unmapped index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real  <= jetp_pkg::CRealRst;
      cfg_q.c_imag  <= jetp_pkg::CImagRst;
      cfg_q.x_start <= jetp_pkg::XStartRst;
      cfg_q.y_start <= jetp_pkg::YStartRst;
      cfg_q.step_x  <= jetp_pkg::StepXRst;
      cfg_q.step_y  <= jetp_pkg::StepYRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input beat enters the front pipe whenever it is not blocked
  assign full = fr_stall;

  jetp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (push),
    .column_i (column_i),
    .row_i    (row_i),
    .stall_o  (fr_stall),
    .valid_o  (fr_valid),
    .point_o  (fr_point),
    .full_i   (mid_full)
  );

  // start points waiting for the loop, lets the front run ahead
  jetp_fifo #(
    .Width (PointW),
    .Depth (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_point),
    .full_o  (mid_full),
    .pop_i   (core_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign core_point = jetp_pkg::point_t'(mid_data);

  jetp_core #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_empty_i (mid_empty),
    .point_i    (core_point),
    .in_pop_o   (core_pop),
    .out_full_i (res_full),
    .out_push_o (core_push),
    .count_o    (core_count)
  );

  // finished counts wait here so the loop can take the next pixel
  jetp_fifo #(
    .Width (jetp_pkg::CountW),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_push),
    .data_i  (core_count),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (iteration_count_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// File: rtl/jetp_fifo.sv
// small first-word-fall-through queue
`timescale 1ns / 1ps
`default_nettype none
`include "julia_escape_time_pixel_macros.svh"

module jetp_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `JETP_ASSERT_ALWAYS(fifo_cnt_bound_a, cnt_q <= CntW'(Depth), "queue count above depth")
  `JETP_ASSERT_RST(fifo_fill_a, (wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + CntW'(1), "queue count lost a write")

endmodule

`default_nettype wire

// File: rtl/jetp_front.sv
// front end: index reduction and start point mapping, four stage pipeline
`timescale 1ns / 1ps
`default_nettype none

module jetp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jetp_pkg::cfg_t                      cfg_i,
  input  logic                                valid_i,
  input  logic [jetp_pkg::IndexW-1:0]         column_i,
  input  logic [jetp_pkg::IndexW-1:0]         row_i,
  output logic                                stall_o,
  output logic                                valid_o,
  output jetp_pkg::point_t                    point_o,
  input  logic                                full_i
);

  localparam int unsigned IdxW  = jetp_pkg::IndexW;
  localparam int unsigned RprodW = IdxW + jetp_pkg::RecipShift;
  localparam int unsigned SubW  = IdxW + jetp_pkg::ResW;
  localparam int unsigned ProdW = IdxW + 1 + jetp_pkg::DataW;
  localparam int unsigned WideW = jetp_pkg::WideW;

  logic [3:0] vld_q;
  logic       adv;

  logic [IdxW-1:0]                 idx_in [2];
  logic signed [jetp_pkg::DataW-1:0] step [2];
  logic signed [jetp_pkg::DataW-1:0] start [2];

  // stage 1: index and quotient estimate
  logic [IdxW-1:0]   idx_q [2];
  logic [IdxW-1:0]   quo_q [2];
  logic [RprodW-1:0] rprod [2];
  // stage 2: reduced index
  logic [IdxW-1:0]   red_q [2];
  logic [SubW-1:0]   rem   [2];
  logic [jetp_pkg::ResW-1:0] rem_x [2];
  // stage 3: index times step
  logic signed [ProdW-1:0] prod_q [2];
  // stage 4: saturated start point
  logic signed [jetp_pkg::DataW-1:0] pt_q [2];

  assign idx_in[0] = column_i;
  assign idx_in[1] = row_i;
  assign step[0]   = cfg_i.step_x;
  assign step[1]   = cfg_i.step_y;
  assign start[0]  = cfg_i.x_start;
  assign start[1]  = cfg_i.y_start;

  // whole pipe moves together unless the last stage is blocked
  assign adv     = !(vld_q[3] && full_i);
  assign stall_o = !adv;
  assign valid_o = vld_q[3];
  assign point_o = '{a: pt_q[0], b: pt_q[1]};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rprod[i] = RprodW'(idx_in[i]) * RprodW'(jetp_pkg::ResRecip);
      rem[i]   = SubW'(idx_q[i]) - SubW'(quo_q[i]) * SubW'(jetp_pkg::MaxResolution);
      rem_x[i] = jetp_pkg::ResW'(rem[i][IdxW-1:0]);
      if (rem_x[i] >= jetp_pkg::ResW'(jetp_pkg::MaxResolution)) begin
        rem_x[i] = rem_x[i] - jetp_pkg::ResW'(jetp_pkg::MaxResolution);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        idx_q[i]  <= idx_in[i];
        quo_q[i]  <= rprod[i][RprodW-1:jetp_pkg::RecipShift];
        red_q[i]  <= IdxW'(rem_x[i]);
        prod_q[i] <= ProdW'($signed({1'b0, red_q[i]})) * ProdW'(step[i]);
        pt_q[i]   <= jetp_pkg::sat(WideW'(start[i]) + WideW'(prod_q[i]));
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/jetp_core.sv
// back end: iterative square-add loop with escape test and counter
`timescale 1ns / 1ps
`default_nettype none
`include "julia_escape_time_pixel_macros.svh"

module jetp_core #(
  parameter int unsigned MAX_ITERATIONS = jetp_pkg::MaxIterations
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jetp_pkg::cfg_t                cfg_i,
  input  logic                          in_empty_i,
  input  jetp_pkg::point_t              point_i,
  output logic                          in_pop_o,
  input  logic                          out_full_i,
  output logic                          out_push_o,
  output logic [jetp_pkg::CountW-1:0]   count_o
);

  localparam int unsigned DataW = jetp_pkg::DataW;
  localparam int unsigned WideW = jetp_pkg::WideW;
  localparam int unsigned CntW  = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StAcc  = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [DataW-1:0]   a_q, a_d, b_q, b_d;
  logic [CntW-1:0]           cnt_q, cnt_d, cnt_inc;
  logic signed [2*DataW-1:0] paa_q, pbb_q, pab_q;
  logic signed [DataW-1:0]   aa, bb, twoab;
  logic signed [DataW+1:0]   sumsq;
  logic                      escape;

  // second half of an iteration: floor shift, clamp, test, update
  assign aa      = jetp_pkg::sat(WideW'(paa_q >>> jetp_pkg::FracBits));
  assign bb      = jetp_pkg::sat(WideW'(pbb_q >>> jetp_pkg::FracBits));
  assign twoab   = jetp_pkg::sat(WideW'(pab_q >>> (jetp_pkg::FracBits - 1)));
  assign sumsq   = (DataW+2)'(aa) + (DataW+2)'(bb);
  assign escape  = sumsq > jetp_pkg::EscapeLimit;
  assign cnt_inc = cnt_q + CntW'(1);
  assign count_o = jetp_pkg::CountW'(cnt_q);

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    cnt_d      = cnt_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          a_d      = point_i.a;
          b_d      = point_i.b;
          cnt_d    = '0;
          state_d  = StMul;
        end
      end
      StMul: begin
        state_d = StAcc;
      end
      StAcc: begin
        if (escape) begin
          state_d = StDone;
        end else begin
          a_d     = jetp_pkg::sat(WideW'(aa) - WideW'(bb) + WideW'(cfg_i.c_real));
          b_d     = jetp_pkg::sat(WideW'(twoab) + WideW'(cfg_i.c_imag));
          cnt_d   = cnt_inc;
          state_d = (cnt_inc == CntW'(MAX_ITERATIONS)) ? StDone : StMul;
        end
      end
      StDone: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    paa_q <= a_q * a_q;
    pbb_q <= b_q * b_q;
    pab_q <= a_q * b_q;
  end

  `JETP_ASSERT_ALWAYS(cnt_bound_a, cnt_q <= CntW'(MAX_ITERATIONS), "count beyond iteration limit")
  `JETP_ASSERT_RST(mul_then_acc_a, state_q == StMul |=> state_q == StAcc && $stable(cnt_q), "multiply not followed by accumulate")
  `JETP_ASSERT_RST(load_starts_a, in_pop_o |=> state_q == StMul && cnt_q == '0, "pixel load did not start a fresh loop")

endmodule

`default_nettype wire
